// ===== hw/rtl/cbw_pkg.sv =====
package cbw_pkg;

    // defaults handed to the top level parameters
    localparam int FRAC_BITS_DEF   = 15;
    localparam int QUEUE_DEPTH_DEF = 2;

    // fixed field widths of the stream items
    localparam int FUNC_W      = 3;
    localparam int T_W         = 16;
    localparam int WEIGHT_W    = 16;
    localparam int NUM_WEIGHTS = 4;
    localparam int KIND_W      = 3;

    // segment variant after classification in the front end
    typedef enum logic [KIND_W-1:0] {
        VAR_UNIFORM = 3'd0,
        VAR_FIRST   = 3'd1,
        VAR_SECOND  = 3'd2,
        VAR_PENULT  = 3'd3,
        VAR_LAST    = 3'd4,
        VAR_NONE    = 3'd5
    } variant_t;

endpackage

// ===== hw/rtl/cbw_front.sv =====
module cbw_front #(
    parameter int FRAC_BITS = cbw_pkg::FRAC_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // tuser: func [2:0]
    input  logic [cbw_pkg::FUNC_W-1:0]                  s_tuser,
    // tdata: t_value [15:0]
    input  logic [cbw_pkg::T_W-1:0]                     s_tdata,
    output logic                                        item_valid,
    input  logic                                        item_ready,
    // item: t [VW-1:0], u [2VW-1:VW], kind above
    output logic [cbw_pkg::KIND_W+2*(FRAC_BITS+1)-1:0]  item_data
);
    import cbw_pkg::*;

    localparam int VW   = FRAC_BITS + 1;
    localparam int EXTW = (VW > T_W) ? VW : T_W;
    localparam logic [VW-1:0]   ONE     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [EXTW-1:0] ONE_EXT = {{(EXTW-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic [EXTW-1:0] t_ext;
    logic [VW-1:0]   t_sat;
    variant_t        kind_d;

    logic            v_reg;
    variant_t        kind_reg;
    logic [VW-1:0]   t_reg;
    logic [VW-1:0]   u_reg;

    // saturate t at one
    always_comb
    begin
        t_ext = EXTW'(s_tdata);
        if (t_ext > ONE_EXT)
        begin
            t_sat = ONE;
        end
        else
        begin
            t_sat = t_ext[VW-1:0];
        end
    end

    // classify the variant select
    always_comb
    begin
        case (s_tuser)
            VAR_UNIFORM: kind_d = VAR_UNIFORM;
            VAR_FIRST:   kind_d = VAR_FIRST;
            VAR_SECOND:  kind_d = VAR_SECOND;
            VAR_PENULT:  kind_d = VAR_PENULT;
            VAR_LAST:    kind_d = VAR_LAST;
            default:     kind_d = VAR_NONE;
        endcase
    end

    assign s_tready   = !v_reg || item_ready;
    assign item_valid = v_reg;
    assign item_data  = {kind_reg, u_reg, t_reg};

    // front register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            v_reg <= s_tvalid;
        end
    end

    // front register payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            kind_reg <= kind_d;
            t_reg    <= t_sat;
            u_reg    <= ONE - t_sat;
        end
    end

endmodule

// ===== hw/rtl/cbw_queue.sv =====
module cbw_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = cbw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);
    import cbw_pkg::*;

    // depth must be a power of two, at least two; the module itself does not enforce this
    localparam int PW = $clog2(DEPTH);
    localparam int CW = PW + 1;

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (PW'(wr_ptr_reg - rd_ptr_reg) == count_reg[PW-1:0]))
        else $error("queue pointers disagree with count");

endmodule

// ===== hw/rtl/cbw_back.sv =====
module cbw_back #(
    parameter int FRAC_BITS = cbw_pkg::FRAC_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          item_valid,
    output logic                                          item_ready,
    input  logic [cbw_pkg::KIND_W+2*(FRAC_BITS+1)-1:0]    item_data,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // tdata: weight_0 [15:0], weight_1 [31:16], weight_2 [47:32], weight_3 [63:48]
    output logic [cbw_pkg::NUM_WEIGHTS*cbw_pkg::WEIGHT_W-1:0] m_tdata
);
    import cbw_pkg::*;

    localparam int VW   = FRAC_BITS + 1;
    localparam int NW   = VW + 8;
    localparam int QW   = FRAC_BITS + 3;
    localparam int DIV_SHIFT = QW + 2;
    localparam int RW   = DIV_SHIFT - 1;
    localparam int PRW  = QW + RW;
    localparam int EXTW = (VW > WEIGHT_W) ? VW : WEIGHT_W;

    localparam logic [VW-1:0]   ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [2*VW-1:0] HALF2 = {{(2*VW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic [63:0]     RECIP_W = ((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3;
    localparam logic [RW-1:0]   RECIP = RECIP_W[RW-1:0];

    localparam logic signed [NW-1:0] S_ONE = {{(NW-VW){1'b0}}, ONE};
    localparam logic signed [NW-1:0] K2  = NW'(2);
    localparam logic signed [NW-1:0] K3  = NW'(3);
    localparam logic signed [NW-1:0] K6  = NW'(6);
    localparam logic signed [NW-1:0] K7  = NW'(7);
    localparam logic signed [NW-1:0] K8  = NW'(8);
    localparam logic signed [NW-1:0] K11 = NW'(11);
    localparam logic signed [NW-1:0] K12 = NW'(12);
    localparam logic signed [NW-1:0] K15 = NW'(15);
    localparam logic signed [NW-1:0] K18 = NW'(18);
    localparam logic signed [NW-1:0] K21 = NW'(21);
    localparam logic signed [NW-1:0] K36 = NW'(36);
    localparam logic signed [NW-1:0] K54 = NW'(54);
    localparam logic signed [NW-1:0] SAT_LIM = (S_ONE <<< 3) + (S_ONE <<< 2) + K6;

    function automatic logic signed [NW-1:0] to_s(input logic [VW-1:0] x);
        return $signed({{(NW-VW){1'b0}}, x});
    endfunction

    logic            adv;
    logic            take;
    variant_t        kind_in;
    logic [VW-1:0]   t_in;
    logic [VW-1:0]   u_in;

    // stage 1: squares
    logic [2*VW-1:0] sq_t_prod;
    logic [2*VW-1:0] sq_u_prod;
    logic            v1_reg;
    variant_t        k1_reg;
    logic [VW-1:0]   t1_reg;
    logic [VW-1:0]   u1_reg;
    logic [VW-1:0]   tt1_reg;
    logic [VW-1:0]   uu1_reg;

    // stage 2: cubes
    logic [2*VW-1:0] cb_t_prod;
    logic [2*VW-1:0] cb_u_prod;
    logic            v2_reg;
    variant_t        k2_reg;
    logic [VW-1:0]   t2_reg;
    logic [VW-1:0]   u2_reg;
    logic [VW-1:0]   tt2_reg;
    logic [VW-1:0]   uu2_reg;
    logic [VW-1:0]   ttt2_reg;
    logic [VW-1:0]   uuu2_reg;

    // stage 3: twelve times each weight
    logic signed [NW-1:0] st;
    logic signed [NW-1:0] st2;
    logic signed [NW-1:0] st3;
    logic signed [NW-1:0] su;
    logic signed [NW-1:0] su2;
    logic signed [NW-1:0] su3;
    logic signed [NW-1:0] n_next [NUM_WEIGHTS];
    logic signed [NW-1:0] n_reg  [NUM_WEIGHTS];
    logic                 v3_reg;

    // stage 4: rounding offset, clamp flags, quarter value
    logic signed [NW-1:0] m_sum    [NUM_WEIGHTS];
    logic                 neg_next [NUM_WEIGHTS];
    logic                 sat_next [NUM_WEIGHTS];
    logic [QW-1:0]        q_next   [NUM_WEIGHTS];
    logic                 neg_reg  [NUM_WEIGHTS];
    logic                 sat_reg  [NUM_WEIGHTS];
    logic [QW-1:0]        q_reg    [NUM_WEIGHTS];
    logic                 v4_reg;

    // output register: divide by three through the reciprocal
    logic [PRW-1:0]       prod     [NUM_WEIGHTS];
    logic [VW-1:0]        w_full   [NUM_WEIGHTS];
    logic [EXTW-1:0]      w_ext    [NUM_WEIGHTS];
    logic [WEIGHT_W-1:0]  w_next   [NUM_WEIGHTS];
    logic [WEIGHT_W-1:0]  w_reg    [NUM_WEIGHTS];
    logic                 o_v_reg;

    // whole pipeline moves unless the output item is held
    assign adv        = !o_v_reg || m_tready;
    assign item_ready = adv;
    assign take       = item_valid && adv;
    assign m_tvalid   = o_v_reg;

    assign kind_in = variant_t'(item_data[2*VW +: KIND_W]);
    assign u_in    = item_data[VW +: VW];
    assign t_in    = item_data[0 +: VW];

    // squares with rounding
    always_comb
    begin
        sq_t_prod = ({{VW{1'b0}}, t_in} * {{VW{1'b0}}, t_in}) + HALF2;
        sq_u_prod = ({{VW{1'b0}}, u_in} * {{VW{1'b0}}, u_in}) + HALF2;
    end

    // cubes with rounding
    always_comb
    begin
        cb_t_prod = ({{VW{1'b0}}, tt1_reg} * {{VW{1'b0}}, t1_reg}) + HALF2;
        cb_u_prod = ({{VW{1'b0}}, uu1_reg} * {{VW{1'b0}}, u1_reg}) + HALF2;
    end

    // polynomial combination per variant
    always_comb
    begin
        st  = to_s(t2_reg);
        st2 = to_s(tt2_reg);
        st3 = to_s(ttt2_reg);
        su  = to_s(u2_reg);
        su2 = to_s(uu2_reg);
        su3 = to_s(uuu2_reg);
        case (k2_reg)
            VAR_UNIFORM:
            begin
                n_next[0] = K2 * su3;
                n_next[1] = K6 * st3 - K12 * st2 + K8 * S_ONE;
                n_next[2] = K6 * st2 + K6 * st + K2 * S_ONE - K6 * st3;
                n_next[3] = K2 * st3;
            end
            VAR_FIRST:
            begin
                n_next[0] = K12 * su3;
                n_next[1] = K21 * st3 - K54 * st2 + K36 * st;
                n_next[2] = K18 * st2 - K11 * st3;
                n_next[3] = K2 * st3;
            end
            VAR_SECOND:
            begin
                n_next[0] = K3 * su3;
                n_next[1] = K7 * st3 - K15 * st2 + K3 * st + K7 * S_ONE;
                n_next[2] = K6 * st2 + K6 * st + K2 * S_ONE - K6 * st3;
                n_next[3] = K2 * st3;
            end
            VAR_PENULT:
            begin
                n_next[0] = K2 * su3;
                n_next[1] = K6 * su2 + K6 * su + K2 * S_ONE - K6 * su3;
                n_next[2] = K7 * su3 - K15 * su2 + K3 * su + K7 * S_ONE;
                n_next[3] = K3 * st3;
            end
            VAR_LAST:
            begin
                n_next[0] = K2 * su3;
                n_next[1] = K18 * su2 - K11 * su3;
                n_next[2] = K21 * su3 - K54 * su2 + K36 * su;
                n_next[3] = K12 * st3;
            end
            default:
            begin
                n_next[0] = '0;
                n_next[1] = '0;
                n_next[2] = '0;
                n_next[3] = '0;
            end
        endcase
    end

    // rounding offset, negative and above-one flags, drop two low bits
    always_comb
    begin
        for (int i = 0; i < NUM_WEIGHTS; i++)
        begin
            m_sum[i]    = n_reg[i] + K6;
            neg_next[i] = n_reg[i][NW-1];
            sat_next[i] = !n_reg[i][NW-1] && (n_reg[i] >= SAT_LIM);
            q_next[i]   = m_sum[i][2 +: QW];
        end
    end

    // divide by three and pick the final weight
    always_comb
    begin
        for (int i = 0; i < NUM_WEIGHTS; i++)
        begin
            prod[i] = {{RW{1'b0}}, q_reg[i]} * {{QW{1'b0}}, RECIP};
            if (neg_reg[i])
            begin
                w_full[i] = '0;
            end
            else if (sat_reg[i])
            begin
                w_full[i] = ONE;
            end
            else
            begin
                w_full[i] = prod[i][DIV_SHIFT +: VW];
            end
            w_ext[i]  = EXTW'(w_full[i]);
            w_next[i] = w_ext[i][WEIGHT_W-1:0];
        end
    end

    // pack result fields
    always_comb
    begin
        for (int i = 0; i < NUM_WEIGHTS; i++)
        begin
            m_tdata[i*WEIGHT_W +: WEIGHT_W] = w_reg[i];
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg  <= take;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            o_v_reg <= v4_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k1_reg   <= kind_in;
            t1_reg   <= t_in;
            u1_reg   <= u_in;
            tt1_reg  <= sq_t_prod[FRAC_BITS +: VW];
            uu1_reg  <= sq_u_prod[FRAC_BITS +: VW];
            k2_reg   <= k1_reg;
            t2_reg   <= t1_reg;
            u2_reg   <= u1_reg;
            tt2_reg  <= tt1_reg;
            uu2_reg  <= uu1_reg;
            ttt2_reg <= cb_t_prod[FRAC_BITS +: VW];
            uuu2_reg <= cb_u_prod[FRAC_BITS +: VW];
            for (int i = 0; i < NUM_WEIGHTS; i++)
            begin
                n_reg[i]   <= n_next[i];
                neg_reg[i] <= neg_next[i];
                sat_reg[i] <= sat_next[i];
                q_reg[i]   <= q_next[i];
                w_reg[i]   <= w_next[i];
            end
        end
    end

    a_take_enters: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> v1_reg)
        else $error("accepted item did not enter the pipeline");

    a_hold_stages: assert property (@(posedge clk) disable iff (!rst_n)
        (o_v_reg && !m_tready) |=>
            (v4_reg == $past(v4_reg)) && (v3_reg == $past(v3_reg)))
        else $error("pipeline moved while the output item was held");

endmodule

// ===== hw/rtl/cubic_bspline_basis_weights_unit.sv =====
// channel  | dir | signals                      | contents
// ---------+-----+------------------------------+----------------------------------
// s        | in  | s_tvalid s_tready s_tuser    | tuser func, tdata t_value
//          |     | s_tdata                      |
// m        | out | m_tvalid m_tready m_tdata    | tdata weight_0 .. weight_3
//
// one item per clock sustained while m_tready stays high; from input accept to output
// valid an item passes the front register, queue slot, square, cube, combine and round
// stages, then the output register that holds the divide-by-three multiply result.
// reset clears the valid bits, queue pointers and fill count only, no clearing pass.
// m_tready low freezes the back pipeline; the queue and the front register
// absorb QUEUE_DEPTH + 1 items before s_tready falls.
module cubic_bspline_basis_weights_unit #(
    parameter int FRAC_BITS   = cbw_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = cbw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              s_tvalid,
    output logic                                              s_tready,
    // tuser: func [2:0]
    input  logic [cbw_pkg::FUNC_W-1:0]                        s_tuser,
    // tdata: t_value [15:0]
    input  logic [cbw_pkg::T_W-1:0]                           s_tdata,
    output logic                                              m_tvalid,
    input  logic                                              m_tready,
    // tdata: weight_0 [15:0], weight_1 [31:16], weight_2 [47:32], weight_3 [63:48]
    output logic [cbw_pkg::NUM_WEIGHTS*cbw_pkg::WEIGHT_W-1:0] m_tdata
);
    import cbw_pkg::*;

    localparam int ITEM_W = KIND_W + 2 * (FRAC_BITS + 1);

    logic              f_valid;
    logic              f_ready;
    logic [ITEM_W-1:0] f_data;
    logic              b_valid;
    logic              b_ready;
    logic [ITEM_W-1:0] b_data;

    // accept and classify
    cbw_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item_data  (f_data)
    );

    // decoupling queue
    cbw_queue #(
        .DATA_W (ITEM_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    // evaluation pipeline
    cbw_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (b_valid),
        .item_ready (b_ready),
        .item_data  (b_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import cbw_pkg::*;

    localparam int    FB        = FRAC_BITS_DEF;
    localparam longint ONE      = longint'(1) << FB;
    localparam longint HALF     = longint'(1) << (FB - 1);
    localparam int    IDLE_LIMIT = 2000;
    localparam int    TAIL_CYCLES = 20;
    localparam int    RANDOM_ITEMS = 1600;

    logic                              clk;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    // tuser: func [2:0]
    logic [FUNC_W-1:0]                 s_tuser;
    // tdata: t_value [15:0]
    logic [T_W-1:0]                    s_tdata;
    logic                              m_tvalid;
    logic                              m_tready;
    // tdata: weight_0 [15:0], weight_1 [31:16], weight_2 [47:32], weight_3 [63:48]
    logic [NUM_WEIGHTS*WEIGHT_W-1:0]   m_tdata;

    logic [NUM_WEIGHTS*WEIGHT_W-1:0]   weights_due[$];
    int                                mismatches;
    int                                idle_cycles;
    int                                stall_left;
    bit                                no_idle;

    cubic_bspline_basis_weights_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // fixed point product with round half up
    function automatic longint q_mul(input longint a, input longint b);
        return (a * b + HALF) >>> FB;
    endfunction

    // divide twelve times the weight by twelve, clamp to [0, 1.0]
    function automatic logic [WEIGHT_W-1:0] round_weight(input longint twelve_w);
        longint w;
        if (twelve_w < 0)
            return '0;
        w = (twelve_w + 6) / 12;
        if (w > ONE)
            w = ONE;
        return w[WEIGHT_W-1:0];
    endfunction

    // expected weights of one segment, packed as on m_tdata
    function automatic logic [NUM_WEIGHTS*WEIGHT_W-1:0] basis_weights(
        input logic [FUNC_W-1:0] func,
        input logic [T_W-1:0]    tval
    );
        longint t, t2, t3, u, u2, u3;
        longint n[NUM_WEIGHTS];
        logic [NUM_WEIGHTS*WEIGHT_W-1:0] packed_w;
        t = (longint'(tval) > ONE) ? ONE : longint'(tval);
        t2 = q_mul(t, t);
        t3 = q_mul(t2, t);
        u = ONE - t;
        u2 = q_mul(u, u);
        u3 = q_mul(u2, u);
        case (variant_t'(func))
            VAR_UNIFORM:
            begin
                n[0] = 2 * u3;
                n[1] = 6 * t3 - 12 * t2 + 8 * ONE;
                n[2] = -6 * t3 + 6 * t2 + 6 * t + 2 * ONE;
                n[3] = 2 * t3;
            end
            VAR_FIRST:
            begin
                n[0] = 12 * u3;
                n[1] = 21 * t3 - 54 * t2 + 36 * t;
                n[2] = -11 * t3 + 18 * t2;
                n[3] = 2 * t3;
            end
            VAR_SECOND:
            begin
                n[0] = 3 * u3;
                n[1] = 7 * t3 - 15 * t2 + 3 * t + 7 * ONE;
                n[2] = -6 * t3 + 6 * t2 + 6 * t + 2 * ONE;
                n[3] = 2 * t3;
            end
            VAR_PENULT:
            begin
                n[0] = 2 * u3;
                n[1] = -6 * u3 + 6 * u2 + 6 * u + 2 * ONE;
                n[2] = 7 * u3 - 15 * u2 + 3 * u + 7 * ONE;
                n[3] = 3 * t3;
            end
            VAR_LAST:
            begin
                n[0] = 2 * u3;
                n[1] = -11 * u3 + 18 * u2;
                n[2] = 21 * u3 - 54 * u2 + 36 * u;
                n[3] = 12 * t3;
            end
            default:
            begin
                n[0] = 0;
                n[1] = 0;
                n[2] = 0;
                n[3] = 0;
            end
        endcase
        for (int k = 0; k < NUM_WEIGHTS; k++)
            packed_w[k*WEIGHT_W +: WEIGHT_W] = round_weight(n[k]);
        return packed_w;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // drive one item, entered and left at a falling edge with tvalid still high
    task automatic send_segment(input logic [FUNC_W-1:0] func, input logic [T_W-1:0] tval);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= tval;
        do
            @(posedge clk);
        while (!s_tready);
        weights_due.push_back(basis_weights(func, tval));
        @(negedge clk);
    endtask

    // sink side stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                if (!no_idle && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
                m_tready <= (stall_left == 0);
            end
        end
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        logic [NUM_WEIGHTS*WEIGHT_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (weights_due.size() == 0)
            begin
                $display("%0t: result with no item pending, actual %h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = weights_due.pop_front();
                for (int k = 0; k < NUM_WEIGHTS; k++)
                begin
                    if (m_tdata[k*WEIGHT_W +: WEIGHT_W] !== want[k*WEIGHT_W +: WEIGHT_W])
                    begin
                        $display("%0t: weight_%0d expected %0d actual %0d", $time, k,
                                 want[k*WEIGHT_W +: WEIGHT_W],
                                 m_tdata[k*WEIGHT_W +: WEIGHT_W]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // both ends of the segment for every variant
    task automatic test_segment_ends();
        for (int f = VAR_UNIFORM; f <= VAR_LAST; f++)
        begin
            send_segment(f[FUNC_W-1:0], 16'd0);
            send_segment(f[FUNC_W-1:0], 16'd32768);
        end
    endtask

    // midpoint and the values next to the ends
    task automatic test_midpoints();
        for (int f = VAR_UNIFORM; f <= VAR_LAST; f++)
            send_segment(f[FUNC_W-1:0], 16'd16384);
        send_segment(VAR_SECOND, 16'd1);
        send_segment(VAR_FIRST, 16'd32767);
    endtask

    // t above one saturates to 1.0
    task automatic test_t_saturation();
        send_segment(VAR_UNIFORM, 16'hFFFF);
        send_segment(VAR_PENULT, 16'd32769);
        send_segment(VAR_FIRST, 16'd40000);
    endtask

    // codes beyond the last variant give zero weights
    task automatic test_unused_variants();
        send_segment(VAR_NONE, 16'hFFFF);
        send_segment(3'd6, 16'd12345);
        send_segment(3'd7, 16'd0);
    endtask

    // random variants and t, with stretches of no idling
    task automatic test_random_segments(input int count);
        logic [FUNC_W-1:0] func;
        logic [T_W-1:0]    tval;
        int                r;
        for (int i = 0; i < count; i++)
        begin
            no_idle = ((i / 100) % 4) == 3;
            r = $urandom_range(0, 99);
            if (r < 80)
                tval = T_W'($urandom_range(0, 32768));
            else if (r < 85)
                tval = T_W'($urandom_range(0, 15));
            else if (r < 90)
                tval = T_W'(32768 - $urandom_range(0, 15));
            else
                tval = T_W'($urandom_range(32769, 65535));
            if ($urandom_range(0, 9) == 0)
                func = FUNC_W'($urandom_range(VAR_NONE, 7));
            else
                func = FUNC_W'($urandom_range(VAR_UNIFORM, VAR_LAST));
            send_segment(func, tval);
        end
        no_idle = 1'b0;
    endtask

    // main sequence
    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = '0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        mismatches  = 0;
        idle_cycles = 0;
        stall_left  = 0;
        no_idle     = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_segment_ends();
        test_midpoints();
        test_t_saturation();
        test_unused_variants();
        test_random_segments(RANDOM_ITEMS);

        s_tvalid <= 1'b0;
        while (weights_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
